>>> sv/pidl_pkg.sv
// shared constants, request and status codes for the positional list core
`default_nettype none
package pidl_pkg;

   localparam int Depth = 16;
   localparam int CountWidth = $clog2(Depth + 1);
   localparam int IdxWidth = $clog2(Depth);
   localparam int PosWidth = 5;
   localparam int OutCountWidth = 5;
   localparam int DataWidth = 32;
   // wide enough for position, count and count + 1
   localparam int CalcWidth = ((CountWidth > PosWidth) ? CountWidth : PosWidth) + 1;

   typedef enum logic [2:0] {
      MODE_INS_FRONT = 3'd0,
      MODE_INS_BACK  = 3'd1,
      MODE_INS_POS   = 3'd2,
      MODE_DEL_FRONT = 3'd3,
      MODE_DEL_BACK  = 3'd4,
      MODE_DEL_POS   = 3'd5,
      MODE_SIZE      = 3'd6,
      MODE_CLEAR     = 3'd7
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_EMPTY = 2'd2,
      STATUS_FULL  = 2'd3
   } status_type;

   typedef struct packed {
      logic load;
      logic exec;
   } cmd_type;

endpackage
`default_nettype wire

>>> sv/pidl_if.sv
// request and response channel interfaces
`default_nettype none
interface pidl_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [2:0]                             mode;
   logic [pidl_pkg::PosWidth-1:0]          position;
   logic signed [pidl_pkg::DataWidth-1:0]  value;

   modport source (output valid, output mode, output position, output value, input ready);
   modport sink (input valid, input mode, input position, input value, output ready);
endinterface

interface pidl_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic [1:0]                             status;
   logic signed [pidl_pkg::DataWidth-1:0]  removed_value;
   logic [pidl_pkg::OutCountWidth-1:0]     element_count;

   modport source (output valid, output status, output removed_value, output element_count,
                   input ready);
   modport sink (input valid, input status, input removed_value, input element_count,
                 output ready);
endinterface
`default_nettype wire

>>> sv/positional_insert_delete_list_core.sv
// Ordered list of up to pidl_pkg::Depth signed 32-bit values kept in a register bank in which
// every entry shifts in parallel, so an insert or delete at any position completes in the
// execute state. Each transaction passes through accept, execute and response: the request
// is taken, the sequencer executes it on the entry bank, and the response is then held until
// the consumer takes it; the next request can be taken in the cycle after that. Every request gives
// one response with status, removed value (zero unless a delete succeeded) and the element
// count after the request. Entry contents are not cleared by reset; only the count is.
`default_nettype none
module positional_insert_delete_list_core (
   input  wire logic  clock,
   input  wire logic  reset,
   pidl_req_if.sink   req_ch,
   pidl_rsp_if.source rsp_ch
);

   pidl_pkg::cmd_type cmd;

   pidl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   pidl_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_mode          (req_ch.mode),
      .req_position      (req_ch.position),
      .req_value         (req_ch.value),
      .rsp_status        (rsp_ch.status),
      .rsp_removed_value (rsp_ch.removed_value),
      .rsp_element_count (rsp_ch.element_count)
   );

endmodule
`default_nettype wire

>>> sv/pidl_ctrl.sv
// request sequencer: accept, execute, hold the response until taken
`default_nettype none
module pidl_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output pidl_pkg::cmd_type      cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RESP
   } state_type;

   state_type state_ff;
   logic      req_ready_ff;
   logic      rsp_valid_ff;

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;
   assign cmd.load  = req_valid && req_ready_ff;
   assign cmd.exec  = (state_ff == ST_EXEC);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_ready_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid && req_ready_ff) begin
                  state_ff     <= ST_EXEC;
                  req_ready_ff <= 1'b0;
               end else begin
                  req_ready_ff <= 1'b1;
               end
            end
            ST_EXEC: begin
               state_ff     <= ST_RESP;
               rsp_valid_ff <= 1'b1;
            end
            ST_RESP: begin
               if (rsp_ready) begin
                  state_ff     <= ST_IDLE;
                  rsp_valid_ff <= 1'b0;
                  req_ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // a new transaction is never taken while a response is pending
   a_no_accept_in_resp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !req_ready_ff)
      else $error("request accepted while response pending");

   a_load_then_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> cmd.exec)
      else $error("accepted request not executed");

   a_exec_then_resp: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> rsp_valid_ff)
      else $error("execution produced no response");

endmodule
`default_nettype wire

>>> sv/pidl_dpath.sv
// entry register bank with parallel shift, count and response registers
`default_nettype none
module pidl_dpath (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire pidl_pkg::cmd_type                     cmd,
   input  wire logic [2:0]                            req_mode,
   input  wire logic [pidl_pkg::PosWidth-1:0]         req_position,
   input  wire logic signed [pidl_pkg::DataWidth-1:0] req_value,
   output logic [1:0]                                 rsp_status,
   output logic signed [pidl_pkg::DataWidth-1:0]      rsp_removed_value,
   output logic [pidl_pkg::OutCountWidth-1:0]         rsp_element_count
);

   localparam int Depth = pidl_pkg::Depth;
   localparam int CountWidth = pidl_pkg::CountWidth;
   localparam int IdxWidth = pidl_pkg::IdxWidth;
   localparam int CalcWidth = pidl_pkg::CalcWidth;
   localparam int DataWidth = pidl_pkg::DataWidth;

   pidl_pkg::mode_type              mode_ff;
   logic [pidl_pkg::PosWidth-1:0]   pos_ff;
   logic signed [DataWidth-1:0]     value_ff;

   logic [CountWidth-1:0]           count_ff;
   logic [CountWidth-1:0]           count_in;
   pidl_pkg::status_type            status_ff;
   pidl_pkg::status_type            status_in;
   logic signed [DataWidth-1:0]     removed_ff;
   logic signed [DataWidth-1:0]     removed_in;

   logic signed [DataWidth-1:0]     entries_ff [Depth];
   logic signed [DataWidth-1:0]     entries_in [Depth];

   logic [CalcWidth-1:0]            count_ext;
   logic [CalcWidth-1:0]            eff_pos;
   logic [IdxWidth-1:0]             tgt;
   logic                            is_full;
   logic                            do_ins;
   logic                            do_del;
   logic                            do_clr;

   assign count_ext = CalcWidth'(count_ff);
   assign is_full   = (count_ff == CountWidth'(Depth));

   always_comb begin
      eff_pos = CalcWidth'(pos_ff);
      do_ins  = 1'b0;
      do_del  = 1'b0;
      do_clr  = 1'b0;
      status_in = pidl_pkg::STATUS_DONE;
      unique case (mode_ff)
         pidl_pkg::MODE_INS_FRONT, pidl_pkg::MODE_INS_BACK, pidl_pkg::MODE_INS_POS: begin
            if (mode_ff == pidl_pkg::MODE_INS_FRONT) begin
               eff_pos = CalcWidth'(1);
            end else if (mode_ff == pidl_pkg::MODE_INS_BACK) begin
               eff_pos = count_ext + CalcWidth'(1);
            end
            if (eff_pos == '0 || eff_pos > count_ext + CalcWidth'(1)) begin
               status_in = pidl_pkg::STATUS_RANGE;
            end else if (is_full) begin
               status_in = pidl_pkg::STATUS_FULL;
            end else begin
               do_ins = 1'b1;
            end
         end
         pidl_pkg::MODE_DEL_FRONT, pidl_pkg::MODE_DEL_BACK: begin
            eff_pos = (mode_ff == pidl_pkg::MODE_DEL_FRONT) ? CalcWidth'(1) : count_ext;
            if (count_ff == '0) begin
               status_in = pidl_pkg::STATUS_EMPTY;
            end else begin
               do_del = 1'b1;
            end
         end
         pidl_pkg::MODE_DEL_POS: begin
            if (eff_pos == '0 || eff_pos > count_ext) begin
               status_in = pidl_pkg::STATUS_RANGE;
            end else begin
               do_del = 1'b1;
            end
         end
         pidl_pkg::MODE_SIZE: begin
         end
         pidl_pkg::MODE_CLEAR: begin
            do_clr = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // zero-based entry that the operation starts at
   assign tgt = IdxWidth'(eff_pos - CalcWidth'(1));

   always_comb begin
      removed_in = '0;
      if (do_del) begin
         removed_in = entries_ff[tgt];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (do_clr) begin
         count_in = '0;
      end else if (do_ins) begin
         count_in = count_ff + CountWidth'(1);
      end else if (do_del) begin
         count_in = count_ff - CountWidth'(1);
      end
   end

   for (genvar g = 0; g < Depth; g++) begin : g_entry
      logic signed [DataWidth-1:0] prev_val;
      logic signed [DataWidth-1:0] next_val;

      if (g == 0) begin : g_first
         assign prev_val = value_ff;
      end else begin : g_mid
         assign prev_val = entries_ff[g-1];
      end

      if (g == Depth - 1) begin : g_last
         assign next_val = entries_ff[g];
      end else begin : g_inner
         assign next_val = entries_ff[g+1];
      end

      always_comb begin
         entries_in[g] = entries_ff[g];
         if (do_ins) begin
            if (IdxWidth'(g) == tgt) begin
               entries_in[g] = value_ff;
            end else if (IdxWidth'(g) > tgt) begin
               entries_in[g] = prev_val;
            end
         end else if (do_del && IdxWidth'(g) >= tgt) begin
            entries_in[g] = next_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff  <= pidl_pkg::mode_type'(req_mode);
         pos_ff   <= req_position;
         value_ff <= req_value;
      end
      if (cmd.exec) begin
         entries_ff <= entries_in;
         status_ff  <= status_in;
         removed_ff <= removed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.exec) begin
         count_ff <= count_in;
      end
   end

   assign rsp_status        = status_ff;
   assign rsp_removed_value = removed_ff;
   assign rsp_element_count = pidl_pkg::OutCountWidth'(count_ff);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountWidth'(Depth))
      else $error("element count beyond capacity");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && do_clr) |=> count_ff == '0)
      else $error("clear left elements");

   a_reject_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && status_in != pidl_pkg::STATUS_DONE) |=> $stable(count_ff))
      else $error("rejected transaction changed the count");

endmodule
`default_nettype wire
